// ===== hdl/svpwm_duty_generator_core_defines.svh =====
// ----------------------------------------------------------------------------
// SVPWM duty generator assertion macros
// Concurrent assertion wrappers, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef SVPWM_DUTY_GENERATOR_CORE_DEFINES_SVH
`define SVPWM_DUTY_GENERATOR_CORE_DEFINES_SVH

// Check while out of reset.
`define SVPWM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every edge, reset included.
`define SVPWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/svpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// SVPWM package
// Widths, constants and word types shared by the duty generator modules.
// ----------------------------------------------------------------------------
package svpwm_pkg;

    localparam int VOLT_W      = 16;
    localparam int FRAC_W      = 15;
    localparam int DUTY_W      = 16;
    localparam int K_W         = 16;
    localparam int PROD_W      = VOLT_W + K_W;
    localparam int PH_W        = VOLT_W + 18;
    localparam int DEN_W       = VOLT_W + 15;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic signed [K_W-1:0] SQRT3_HALF_Q15 = 16'sd28378;
    localparam logic [DUTY_W-1:0]     DUTY_HALF      = DUTY_W'(1) << (FRAC_W - 1);
    localparam logic [DUTY_W:0]       DUTY_FULL      = (DUTY_W + 1)'(1) << FRAC_W;

    typedef struct packed {
        logic signed [VOLT_W-1:0] v_alpha;
        logic signed [VOLT_W-1:0] v_beta;
        logic signed [VOLT_W-1:0] bus_voltage;
    } t_svpwm_in;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_u;
        logic [DUTY_W-1:0] duty_v;
        logic [DUTY_W-1:0] duty_w;
        logic              status;
    } t_svpwm_out;

    typedef struct packed {
        logic                 ok;
        logic [2:0]           neg;
        logic [2:0][PH_W-1:0] mag;
        logic [DEN_W-1:0]     den;
    } t_work;

    typedef struct packed {
        logic                    vld;
        logic                    ok;
        logic [2:0]              neg;
        logic [2:0]              sat;
        logic [2:0][DEN_W-1:0]   rem;
        logic [2:0][FRAC_W-1:0]  quo;
        logic [DEN_W-1:0]        den;
    } t_div_st;

endpackage

// ===== hdl/svpwm_front.sv =====
// ----------------------------------------------------------------------------
// SVPWM front end
// Inverse Clarke, min-max injection and sign/magnitude split, five stages.
// ----------------------------------------------------------------------------
module svpwm_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  svpwm_pkg::t_svpwm_in  i_cmd,
    input  logic                  i_stall,
    output logic                  o_vld,
    output svpwm_pkg::t_work      o_work
);
    import svpwm_pkg::*;

    logic                     r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    logic                     r1_ok, r2_ok, r3_ok, r4_ok, r5_ok;
    logic [DEN_W-1:0]         r1_den, r2_den, r3_den, r4_den, r5_den;
    logic signed [PH_W-1:0]   r1_u, r1_ah;
    logic signed [PROD_W-1:0] r1_bk;
    logic signed [PH_W-1:0]   r2_p [3];
    logic signed [PH_W-1:0]   r3_p [3];
    logic signed [PH_W-1:0]   r3_sum;
    logic signed [PH_W-1:0]   r4_num [3];
    logic [2:0]               r5_neg;
    logic [2:0][PH_W-1:0]     r5_mag;

    logic signed [PH_W-1:0]   n1_u, n1_ah, n2_bk;
    logic signed [PROD_W-1:0] n1_bk;
    logic                     n1_ok;
    logic [DEN_W-1:0]         n1_den;
    logic signed [PH_W-1:0]   n3_mx, n3_mn;

    always_comb begin
        n1_u   = PH_W'($signed(i_cmd.v_alpha)) <<< 15;
        n1_ah  = PH_W'($signed(i_cmd.v_alpha)) <<< 14;
        n1_bk  = $signed(i_cmd.v_beta) * SQRT3_HALF_Q15;
        n1_ok  = !i_cmd.bus_voltage[VOLT_W-1] && (i_cmd.bus_voltage != '0);
        n1_den = {i_cmd.bus_voltage[VOLT_W-2:0], 16'b0};
        n2_bk  = PH_W'(r1_bk);
    end

    always_comb begin
        n3_mx = r2_p[0];
        n3_mn = r2_p[0];
        for (int i = 1; i < 3; i++) begin
            if (r2_p[i] > n3_mx) begin
                n3_mx = r2_p[i];
            end
            if (r2_p[i] < n3_mn) begin
                n3_mn = r2_p[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (!i_stall) begin
            r1_vld <= i_accept;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_stall) begin
            r1_u   <= n1_u;
            r1_ah  <= n1_ah;
            r1_bk  <= n1_bk;
            r1_ok  <= n1_ok;
            r1_den <= n1_den;

            r2_p[0] <= r1_u;
            r2_p[1] <= n2_bk - r1_ah;
            r2_p[2] <= -r1_ah - n2_bk;
            r2_ok   <= r1_ok;
            r2_den  <= r1_den;

            r3_p   <= r2_p;
            r3_sum <= n3_mx + n3_mn;
            r3_ok  <= r2_ok;
            r3_den <= r2_den;

            for (int i = 0; i < 3; i++) begin
                r4_num[i] <= (r3_p[i] <<< 1) - r3_sum;
            end
            r4_ok  <= r3_ok;
            r4_den <= r3_den;

            for (int i = 0; i < 3; i++) begin
                r5_neg[i] <= r4_num[i][PH_W-1];
                r5_mag[i] <= r4_num[i][PH_W-1] ? PH_W'(-r4_num[i]) : PH_W'(r4_num[i]);
            end
            r5_ok  <= r4_ok;
            r5_den <= r4_den;
        end
    end

    assign o_vld       = r5_vld && !i_stall;
    assign o_work.ok   = r5_ok;
    assign o_work.neg  = r5_neg;
    assign o_work.mag  = r5_mag;
    assign o_work.den  = r5_den;

endmodule

// ===== hdl/svpwm_queue.sv =====
// ----------------------------------------------------------------------------
// SVPWM work queue
// Small FIFO between front end and divider, registered read word.
// ----------------------------------------------------------------------------
module svpwm_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  svpwm_pkg::t_work  i_data,
    output logic              o_full,
    output logic              o_vld,
    output svpwm_pkg::t_work  o_data
);
    import svpwm_pkg::*;

    t_work              r_mem [QUEUE_DEPTH];
    t_work              r_rd_data;
    logic               r_rd_vld;
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]    r_count, n_count;
    logic               pop;

    assign pop     = (r_count != '0);
    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign n_count = r_count + (QPTR_W + 1)'(i_push) - (QPTR_W + 1)'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count  <= n_count;
            r_rd_vld <= pop;
        end
    end

    assign o_vld  = r_rd_vld;
    assign o_data = r_rd_data;

endmodule

// ===== hdl/svpwm_back.sv =====
// ----------------------------------------------------------------------------
// SVPWM back end
// Pipelined restoring divider, one quotient bit per stage, and duty saturate.
// ----------------------------------------------------------------------------
module svpwm_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    input  svpwm_pkg::t_work       i_work,
    output logic                   o_valid,
    output svpwm_pkg::t_svpwm_out  o_result
);
    import svpwm_pkg::*;

    t_div_st    r_st [FRAC_W+1];
    t_div_st    n_st [FRAC_W+1];
    t_svpwm_out r_out, n_out;
    logic       r_out_vld;

    function automatic logic [DUTY_W-1:0] f_duty(input logic neg, input logic sat,
                                                 input logic [FRAC_W-1:0] quo);
        logic [DUTY_W:0] q;
        logic [DUTY_W:0] sum;
        logic [DUTY_W:0] half;
        q    = sat ? DUTY_FULL : (DUTY_W + 1)'(quo);
        half = (DUTY_W + 1)'(DUTY_HALF);
        sum  = half + q;
        if (neg) begin
            f_duty = (q >= half) ? '0 : DUTY_W'(half - q);
        end else begin
            f_duty = (sum > DUTY_FULL) ? DUTY_W'(DUTY_FULL) : DUTY_W'(sum);
        end
    endfunction

    always_comb begin
        n_st[0].vld = i_vld;
        n_st[0].ok  = i_work.ok;
        n_st[0].neg = i_work.neg;
        n_st[0].den = i_work.den;
        n_st[0].quo = '0;
        for (int i = 0; i < 3; i++) begin
            n_st[0].sat[i] = (i_work.mag[i] >= PH_W'(i_work.den));
            n_st[0].rem[i] = n_st[0].sat[i] ? '0 : i_work.mag[i][DEN_W-1:0];
        end
    end

    for (genvar k = 0; k < FRAC_W; k++) begin : g_div
        always_comb begin
            logic [DEN_W:0] sh;
            logic [DEN_W:0] df;
            n_st[k+1] = r_st[k];
            for (int i = 0; i < 3; i++) begin
                sh = {r_st[k].rem[i], 1'b0};
                df = sh - {1'b0, r_st[k].den};
                if (sh >= {1'b0, r_st[k].den}) begin
                    n_st[k+1].rem[i] = df[DEN_W-1:0];
                    n_st[k+1].quo[i] = {r_st[k].quo[i][FRAC_W-2:0], 1'b1};
                end else begin
                    n_st[k+1].rem[i] = sh[DEN_W-1:0];
                    n_st[k+1].quo[i] = {r_st[k].quo[i][FRAC_W-2:0], 1'b0};
                end
            end
        end
    end

    for (genvar k = 0; k <= FRAC_W; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k].vld <= 1'b0;
            end else begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_comb begin
        if (r_st[FRAC_W].ok) begin
            n_out.duty_u = f_duty(r_st[FRAC_W].neg[0], r_st[FRAC_W].sat[0],
                                  r_st[FRAC_W].quo[0]);
            n_out.duty_v = f_duty(r_st[FRAC_W].neg[1], r_st[FRAC_W].sat[1],
                                  r_st[FRAC_W].quo[1]);
            n_out.duty_w = f_duty(r_st[FRAC_W].neg[2], r_st[FRAC_W].sat[2],
                                  r_st[FRAC_W].quo[2]);
            n_out.status = 1'b1;
        end else begin
            n_out.duty_u = DUTY_HALF;
            n_out.duty_v = DUTY_HALF;
            n_out.duty_w = DUTY_HALF;
            n_out.status = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_st[FRAC_W].vld;
        end
        r_out <= n_out;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

// ===== hdl/svpwm_duty_generator_core.sv =====
// ----------------------------------------------------------------------------
// SVPWM duty generator core
// Alpha/beta vector and bus voltage in, three min-max injected duties out.
// ----------------------------------------------------------------------------
// One command word is taken per clock whenever busy is low. The result word
// appears on o_result with o_valid high for one cycle. Results leave in
// command order and cannot be held off. The path holds five front-end
// stages (the first loaded at the accepting edge), the queue write and its
// registered read, a saturation-check stage, fifteen divider stages
// (one quotient bit per stage, per phase) and one output register. busy rises
// only if the four-word queue between the front end and the divider fills.
// The free-running divider does not let that happen in use.
module svpwm_duty_generator_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  svpwm_pkg::t_svpwm_in   i_cmd,
    output logic                   o_valid,
    output svpwm_pkg::t_svpwm_out  o_result
);
    import svpwm_pkg::*;

    logic  accept;
    logic  q_full;
    logic  fe_vld;
    t_work fe_work;
    logic  q_vld;
    t_work q_work;

    assign busy   = q_full;
    assign accept = start && !busy;

    svpwm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (i_cmd),
        .i_stall  (q_full),
        .o_vld    (fe_vld),
        .o_work   (fe_work)
    );

    svpwm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_vld),
        .i_data  (fe_work),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_data  (q_work)
    );

    svpwm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (q_vld),
        .i_work   (q_work),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

// ===== hdl/svpwm_checker.sv =====
// ----------------------------------------------------------------------------
// SVPWM port checker
// Port-level checks on the duty generator core, attached by bind.
// ----------------------------------------------------------------------------
`include "svpwm_duty_generator_core_defines.svh"

module svpwm_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input svpwm_pkg::t_svpwm_in   i_cmd,
    input logic                   o_valid,
    input svpwm_pkg::t_svpwm_out  o_result
);
    import svpwm_pkg::*;

    `SVPWM_ASSERT_ALWAYS(a_rst_valid, i_clk, !i_rst_n |=> !o_valid, "valid after reset")
    `SVPWM_ASSERT_ALWAYS(a_rst_busy, i_clk, !i_rst_n |=> !busy, "busy after reset")
    `SVPWM_ASSERT(a_cmd_known, i_clk, i_rst_n, (start && !busy) |-> !$isunknown(i_cmd), "unknown command word accepted")
    `SVPWM_ASSERT(a_centered, i_clk, i_rst_n, (o_valid && !o_result.status) |-> (o_result.duty_u == DUTY_HALF && o_result.duty_v == DUTY_HALF && o_result.duty_w == DUTY_HALF), "invalid bus word not centered")
    `SVPWM_ASSERT(a_range, i_clk, i_rst_n, (o_valid && o_result.status) |-> ((DUTY_W + 1)'(o_result.duty_u) <= DUTY_FULL && (DUTY_W + 1)'(o_result.duty_v) <= DUTY_FULL && (DUTY_W + 1)'(o_result.duty_w) <= DUTY_FULL), "duty above full scale")

endmodule

bind svpwm_duty_generator_core svpwm_checker u_svpwm_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SVPWM duty generator core testbench
// Sends alpha/beta/bus command words through the start/busy handshake and
// checks each result word against a min-max injection duty predictor.
// ----------------------------------------------------------------------------
module tb;
    import svpwm_pkg::*;

    typedef struct {
        bit          hold;
        int unsigned gap_pct;
        t_svpwm_in   cmd;
    } t_pending;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    logic       busy;
    t_svpwm_in  i_cmd   = '0;
    logic       o_valid;
    t_svpwm_out o_result;

    t_pending   pending_words[$];
    t_svpwm_out expected_duties[$];
    int         mismatches = 0;

    svpwm_duty_generator_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Truncated phase/bus quotient plus one half, saturated to 0 .. full.
    function automatic logic [DUTY_W-1:0] phase_duty_of(longint num, longint den);
        longint unsigned mag, rem, quo, full, half, dv;
        full = 64'd1 << FRAC_W;
        half = 64'd1 << (FRAC_W - 1);
        dv   = longint'(den);
        mag  = (num < 0) ? longint'(-num) : longint'(num);
        if (mag >= dv) begin
            quo = full;
        end else begin
            rem = mag;
            quo = 0;
            for (int i = 0; i < FRAC_W; i++) begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= dv) begin
                    rem = rem - dv;
                    quo = quo | 64'd1;
                end
            end
        end
        if (num < 0)
            return (quo >= half) ? '0 : DUTY_W'(half - quo);
        return (half + quo > full) ? DUTY_W'(full) : DUTY_W'(half + quo);
    endfunction

    function automatic t_svpwm_out predict_duties(t_svpwm_in cmd);
        t_svpwm_out res;
        longint alpha, beta, bus, pu, pv, pw, hi, lo, den, k;
        alpha = longint'(cmd.v_alpha);
        beta  = longint'(cmd.v_beta);
        bus   = longint'(cmd.bus_voltage);
        k     = longint'(SQRT3_HALF_Q15);
        if (bus <= 0) begin
            res.duty_u = DUTY_HALF;
            res.duty_v = DUTY_HALF;
            res.duty_w = DUTY_HALF;
            res.status = 1'b0;
            return res;
        end
        pu = alpha * 32768;
        pv = -alpha * 16384 + beta * k;
        pw = -alpha * 16384 - beta * k;
        hi = pu;
        if (pv > hi) hi = pv;
        if (pw > hi) hi = pw;
        lo = pu;
        if (pv < lo) lo = pv;
        if (pw < lo) lo = pw;
        den = bus * 65536;
        res.duty_u = phase_duty_of(2 * pu - (hi + lo), den);
        res.duty_v = phase_duty_of(2 * pv - (hi + lo), den);
        res.duty_w = phase_duty_of(2 * pw - (hi + lo), den);
        res.status = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [DUTY_W-1:0] got,
                                   logic [DUTY_W-1:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic queue_word(logic signed [VOLT_W-1:0] alpha,
                              logic signed [VOLT_W-1:0] beta,
                              logic signed [VOLT_W-1:0] bus, int unsigned gap);
        t_pending item;
        item.hold            = 1'b0;
        item.gap_pct         = gap;
        item.cmd.v_alpha     = alpha;
        item.cmd.v_beta      = beta;
        item.cmd.bus_voltage = bus;
        pending_words.push_back(item);
    endtask

    task automatic queue_drain_pause();
        t_pending item;
        item.hold    = 1'b1;
        item.gap_pct = 0;
        item.cmd     = '0;
        pending_words.push_back(item);
    endtask

    task automatic queue_random(int unsigned gap);
        int sel, bus, span, alpha, beta;
        sel = $urandom_range(99);
        if (sel < 8)
            bus = -int'($urandom_range(32768));
        else if ($urandom_range(3) == 0)
            bus = $urandom_range(1, 64);
        else
            bus = $urandom_range(1, 32767);
        if (sel < 40) begin
            alpha = $urandom;
            beta  = $urandom;
        end else begin
            span  = (bus > 0) ? bus : 32767;
            alpha = int'($urandom_range(0, 2 * span)) - span;
            beta  = int'($urandom_range(0, 2 * span)) - span;
        end
        queue_word(VOLT_W'(alpha), VOLT_W'(beta), VOLT_W'(bus), gap);
    endtask

    // Driver: hold a word until taken, idle at random, drain on a hold marker.
    always @(posedge i_clk) begin
        logic      take;
        logic      next_start;
        t_svpwm_in next_cmd;
        t_pending  item;
        take       = 1'b0;
        next_start = 1'b0;
        next_cmd   = i_cmd;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cmd <= '0;
        end else begin
            take = start && !busy;
            if (take)
                expected_duties.push_back(predict_duties(i_cmd));
            if (!(start && !take)) begin
                if (pending_words.size() != 0 && pending_words[0].hold) begin
                    if (expected_duties.size() == 0)
                        void'(pending_words.pop_front());
                end else if (pending_words.size() != 0 &&
                             $urandom_range(99) >= pending_words[0].gap_pct) begin
                    item       = pending_words.pop_front();
                    next_start = 1'b1;
                    next_cmd   = item.cmd;
                end
                start <= next_start;
                i_cmd <= next_cmd;
            end
        end
    end

    // Monitor: compare every result word with the oldest prediction.
    always @(posedge i_clk) begin
        t_svpwm_out want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_duties.size() == 0) begin
                report_mismatch("unexpected word", o_result.duty_u, '0);
            end else begin
                want = expected_duties.pop_front();
                if (o_result.duty_u !== want.duty_u)
                    report_mismatch("duty_u", o_result.duty_u, want.duty_u);
                if (o_result.duty_v !== want.duty_v)
                    report_mismatch("duty_v", o_result.duty_v, want.duty_v);
                if (o_result.duty_w !== want.duty_w)
                    report_mismatch("duty_w", o_result.duty_w, want.duty_w);
                if (o_result.status !== want.status)
                    report_mismatch("status", DUTY_W'(o_result.status), DUTY_W'(want.status));
            end
        end
    end

    initial begin
        // Directed: invalid bus, zero vector, extremes, saturation.
        queue_word(16'sd1000, 16'sd2000, 16'sd0, 15);
        queue_word(-16'sd32768, 16'sd32767, -16'sd1, 15);
        queue_word(16'sd32767, -16'sd32768, -16'sd32768, 15);
        queue_word(16'sd0, 16'sd0, 16'sd1, 15);
        queue_word(16'sd0, 16'sd0, 16'sd32767, 15);
        queue_word(16'sd32767, 16'sd0, 16'sd32767, 15);
        queue_word(-16'sd32768, 16'sd0, 16'sd32767, 15);
        queue_word(16'sd0, 16'sd32767, 16'sd32767, 15);
        queue_word(16'sd0, -16'sd32768, 16'sd32767, 15);
        queue_word(16'sd32767, 16'sd32767, 16'sd32767, 15);
        queue_word(-16'sd32768, -16'sd32768, 16'sd32767, 15);
        queue_word(16'sd32767, -16'sd32768, 16'sd1, 15);
        queue_word(-16'sd32768, 16'sd32767, 16'sd1, 15);
        queue_word(16'sd1, 16'sd0, 16'sd1, 15);
        queue_word(-16'sd1, 16'sd1, 16'sd2, 15);
        queue_word(16'sd10000, 16'sd5000, 16'sd20000, 15);
        queue_word(-16'sd12000, 16'sd7000, 16'sd16000, 15);
        queue_word(16'sd16000, 16'sd0, 16'sd16000, 15);
        queue_word(16'sd100, -16'sd100, 16'sd32767, 15);
        queue_word(16'sd0, 16'sd18000, 16'sd20000, 15);
        queue_drain_pause();
        for (int i = 0; i < 700; i++) queue_random(15);
        queue_drain_pause();
        for (int i = 0; i < 700; i++) queue_random(53);
        queue_drain_pause();
        for (int i = 0; i < 600; i++) queue_random(0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || start) @(posedge i_clk);
        while (expected_duties.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("svpwm_duty_generator_core verification clean");
        else
            $display("svpwm_duty_generator_core verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("svpwm_duty_generator_core verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/svpwm_pkg.sv
hdl/svpwm_front.sv
hdl/svpwm_queue.sv
hdl/svpwm_back.sv
hdl/svpwm_duty_generator_core.sv
hdl/svpwm_checker.sv
test/tb.sv
